>>> design/frwl_pkg.sv
// Shared types and codes for the FIFO-fair reader/writer lock.
package frwl_pkg;

   localparam int IdWidth    = 8;
   localparam int MaxResults = 16;

   typedef enum logic [1:0] {
      ACT_READ    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_RELEASE = 2'd2
   } frwl_action_type;

   typedef enum logic [2:0] {
      STAT_GRANTED     = 3'd0,
      STAT_QUEUED      = 3'd1,
      STAT_NONE        = 3'd2,
      STAT_FULL        = 3'd3,
      STAT_BAD_RELEASE = 3'd4
   } frwl_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SERVE
   } frwl_state_type;

   typedef struct packed {
      logic               read_flag;
      logic [IdWidth-1:0] id;
   } frwl_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } frwl_qctl_type;

endpackage

>>> design/fifo_fair_reader_writer_lock.sv
// Top level of the FIFO-fair reader/writer lock manager.
//
// A transaction is taken when start is high and busy is low; busy drops in the cycle that
// shows its final result. Read and write requests, unused action codes and releases with
// nothing held give one result. Any other release gives one grant for each queued reader
// it serves from the head (up to 16), or one grant for a writer at the head, or one empty
// result if it serves none. The sequencer serves the queue head one entry per cycle
// through the queue's registered read port and a single increment/decrement unit on the
// reader count. Each result shows on the rsp_ ports for exactly one cycle with rsp_valid
// high and cannot be held off; the last result of a transaction carries rsp_last.
module fifo_fair_reader_writer_lock #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_READERS = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [frwl_pkg::IdWidth-1:0]  req_requester_id,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [frwl_pkg::IdWidth-1:0]  rsp_grant_id,
   output logic                          rsp_grant_is_reader,
   output logic                          rsp_last
);

   localparam int CountBits  = $clog2(QUEUE_DEPTH + 1);
   localparam int ReaderBits = $clog2(MAX_READERS + 1);
   localparam int ResultBits = $clog2(frwl_pkg::MaxResults + 1);

   frwl_pkg::frwl_state_type state_ff, state_in;

   logic [1:0]                   action_ff, action_in;
   logic [frwl_pkg::IdWidth-1:0] id_ff, id_in;
   logic                         writer_ff, writer_in;
   logic [ReaderBits-1:0]        readers_ff, readers_in;
   logic [ResultBits-1:0]        n_ff, n_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [frwl_pkg::IdWidth-1:0] pend_id_ff, pend_id_in;

   logic                         out_valid_ff, out_valid_in;
   logic [2:0]                   out_status_ff, out_status_in;
   logic [frwl_pkg::IdWidth-1:0] out_id_ff, out_id_in;
   logic                         out_reader_ff, out_reader_in;
   logic                         out_last_ff, out_last_in;

   frwl_pkg::frwl_qctl_type  q_ctl;
   frwl_pkg::frwl_entry_type q_push_entry;
   frwl_pkg::frwl_entry_type q_head;
   logic [CountBits-1:0]     q_count;
   logic                     q_full;

   logic                  adder_dec;
   logic [ReaderBits-1:0] readers_sum;
   logic                  req_read;
   logic                  can_grant;
   logic                  q_empty;
   logic                  release_ok;
   logic                  take_reader;
   logic                  take_writer;

   frwl_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (q_ctl),
      .push_entry (q_push_entry),
      .head_entry (q_head),
      .count      (q_count),
      .full       (q_full)
   );

   assign readers_sum = readers_ff + (adder_dec ? {ReaderBits{1'b1}} : ReaderBits'(1));
   assign req_read    = (action_ff == frwl_pkg::ACT_READ);
   assign q_empty     = (q_count == '0);
   assign release_ok  = writer_ff || (readers_ff != '0);
   assign can_grant   = q_empty && !writer_ff &&
                        (req_read ? (readers_ff != ReaderBits'(MAX_READERS))
                                  : (readers_ff == '0));
   assign take_reader = !q_empty && q_head.read_flag && !writer_ff &&
                        (n_ff != ResultBits'(frwl_pkg::MaxResults)) &&
                        (readers_ff != ReaderBits'(MAX_READERS));
   assign take_writer = !q_empty && !q_head.read_flag && !writer_ff &&
                        (readers_ff == '0) && (n_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frwl_pkg::S_IDLE: begin
            if (start) begin
               state_in = frwl_pkg::S_EXEC;
            end
         end
         frwl_pkg::S_EXEC: begin
            if (action_ff == frwl_pkg::ACT_RELEASE && release_ok) begin
               state_in = frwl_pkg::S_SERVE;
            end else begin
               state_in = frwl_pkg::S_IDLE;
            end
         end
         frwl_pkg::S_SERVE: begin
            if (!take_reader) begin
               state_in = frwl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = frwl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      action_in     = action_ff;
      id_in         = id_ff;
      writer_in     = writer_ff;
      readers_in    = readers_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      out_valid_in  = 1'b0;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_reader_in = out_reader_ff;
      out_last_in   = out_last_ff;
      adder_dec     = 1'b0;
      q_ctl         = '0;
      q_push_entry  = '{read_flag: req_read, id: id_ff};
      unique case (state_ff)
         frwl_pkg::S_IDLE: begin
            if (start) begin
               action_in     = req_action;
               id_in         = req_requester_id;
               n_in          = '0;
               pend_valid_in = 1'b0;
            end
         end
         frwl_pkg::S_EXEC: begin
            out_valid_in  = 1'b1;
            out_last_in   = 1'b1;
            out_id_in     = id_ff;
            out_reader_in = req_read;
            unique case (action_ff)
               frwl_pkg::ACT_READ, frwl_pkg::ACT_WRITE: begin
                  priority if (can_grant) begin
                     out_status_in = frwl_pkg::STAT_GRANTED;
                     if (req_read) begin
                        readers_in = readers_sum;
                     end else begin
                        writer_in = 1'b1;
                     end
                  end else if (q_full) begin
                     out_status_in = frwl_pkg::STAT_FULL;
                  end else begin
                     q_ctl.push    = 1'b1;
                     out_status_in = frwl_pkg::STAT_QUEUED;
                  end
               end
               frwl_pkg::ACT_RELEASE: begin
                  out_id_in     = '0;
                  out_reader_in = 1'b0;
                  priority if (writer_ff) begin
                     writer_in    = 1'b0;
                     out_valid_in = 1'b0;
                  end else if (readers_ff != '0) begin
                     adder_dec    = 1'b1;
                     readers_in   = readers_sum;
                     out_valid_in = 1'b0;
                  end else begin
                     out_status_in = frwl_pkg::STAT_BAD_RELEASE;
                  end
               end
               default: begin
                  out_status_in = frwl_pkg::STAT_NONE;
                  out_id_in     = '0;
                  out_reader_in = 1'b0;
               end
            endcase
         end
         frwl_pkg::S_SERVE: begin
            priority if (take_reader) begin
               readers_in    = readers_sum;
               q_ctl.pop     = 1'b1;
               n_in          = n_ff + ResultBits'(1);
               pend_valid_in = 1'b1;
               pend_id_in    = q_head.id;
               out_valid_in  = pend_valid_ff;
               out_status_in = frwl_pkg::STAT_GRANTED;
               out_id_in     = pend_id_ff;
               out_reader_in = 1'b1;
               out_last_in   = 1'b0;
            end else if (take_writer) begin
               writer_in     = 1'b1;
               q_ctl.pop     = 1'b1;
               out_valid_in  = 1'b1;
               out_status_in = frwl_pkg::STAT_GRANTED;
               out_id_in     = q_head.id;
               out_reader_in = 1'b0;
               out_last_in   = 1'b1;
            end else if (pend_valid_ff) begin
               out_valid_in  = 1'b1;
               out_status_in = frwl_pkg::STAT_GRANTED;
               out_id_in     = pend_id_ff;
               out_reader_in = 1'b1;
               out_last_in   = 1'b1;
            end else begin
               out_valid_in  = 1'b1;
               out_status_in = frwl_pkg::STAT_NONE;
               out_id_in     = '0;
               out_reader_in = 1'b0;
               out_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frwl_pkg::S_IDLE;
         writer_ff     <= 1'b0;
         readers_ff    <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         writer_ff     <= writer_in;
         readers_ff    <= readers_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      id_ff         <= id_in;
      pend_id_ff    <= pend_id_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_reader_ff <= out_reader_in;
      out_last_ff   <= out_last_in;
   end

   assign busy                = (state_ff != frwl_pkg::S_IDLE);
   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_grant_id        = out_id_ff;
   assign rsp_grant_is_reader = out_reader_ff;
   assign rsp_last            = out_last_ff;

endmodule

>>> design/frwl_queue.sv
// Ring-buffer wait queue with a registered read port at the head.
module frwl_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  frwl_pkg::frwl_qctl_type         ctl,
   input  frwl_pkg::frwl_entry_type        push_entry,
   output frwl_pkg::frwl_entry_type        head_entry,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
   output logic                            full
);

   localparam int PtrBits   = $clog2(QUEUE_DEPTH);
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   frwl_pkg::frwl_entry_type mem [QUEUE_DEPTH];
   frwl_pkg::frwl_entry_type head_entry_ff;

   logic [PtrBits-1:0]   head_ff, head_in;
   logic [PtrBits-1:0]   tail_ff, tail_in;
   logic [CountBits-1:0] count_ff, count_in;

   function automatic logic [PtrBits-1:0] wrap_inc(input logic [PtrBits-1:0] ptr);
      logic [PtrBits-1:0] nxt;
      if (ptr == PtrBits'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PtrBits'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      head_in  = ctl.pop  ? wrap_inc(head_ff) : head_ff;
      tail_in  = ctl.push ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff;
      priority if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CountBits'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_entry;
      end
      head_entry_ff <= mem[head_in];
   end

   assign head_entry = head_entry_ff;
   assign count      = count_ff;
   assign full       = (count_ff == CountBits'(QUEUE_DEPTH));

endmodule

>>> design/frwl_checker.sv
// Port-level checks on the lock manager, bound to its top level.
module frwl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [2:0]                   rsp_status,
   input logic [frwl_pkg::IdWidth-1:0] rsp_grant_id,
   input logic                         rsp_grant_is_reader,
   input logic                         rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted transaction");

   a_more_means_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   a_more_is_reader_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
         rsp_status == frwl_pkg::STAT_GRANTED && rsp_grant_is_reader)
      else $error("non-final result is not a reader grant");

   a_empty_result_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == frwl_pkg::STAT_NONE ||
                    rsp_status == frwl_pkg::STAT_BAD_RELEASE) |->
         rsp_last && rsp_grant_id == '0 && !rsp_grant_is_reader)
      else $error("empty result carries payload or is not final");

endmodule

bind fifo_fair_reader_writer_lock frwl_checker u_frwl_checker (.*);
